>>> rtl/bp2r_pkg.sv
// shared types, codes and constants for the bitmap pixel to rgb24 converter
// no dependencies
package bp2r_pkg;

  localparam int PAL_ENTRIES = 256;
  localparam int PAL_AW      = $clog2(PAL_ENTRIES);
  localparam int COL_W       = 16;
  localparam int JQ_DEPTH    = 4;
  localparam int OQ_DEPTH    = 4;
  localparam int REG_IDX_W   = 3;
  localparam int CFG_DW      = 32;

  localparam logic OP_PIXEL  = 1'b0;
  localparam logic OP_PAL_WR = 1'b1;

  typedef enum logic [2:0] {
    FMT_1BPP, FMT_4BPP, FMT_8BPP, FMT_16BPP, FMT_24BPP, FMT_32BPP, FMT_64BPP
  } fmt_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FORMAT, REG_WIDTH, REG_CUSTOM, REG_RED_MASK, REG_GREEN_MASK, REG_BLUE_MASK
  } reg_idx_t;

  localparam logic [31:0] MASK16_R = 32'h0000_7C00;
  localparam logic [31:0] MASK16_G = 32'h0000_03E0;
  localparam logic [31:0] MASK16_B = 32'h0000_001F;
  localparam logic [31:0] MASK32_R = 32'h00FF_0000;
  localparam logic [31:0] MASK32_G = 32'h0000_FF00;
  localparam logic [31:0] MASK32_B = 32'h0000_00FF;
  localparam logic [4:0]  TOP16_R  = 5'd14;
  localparam logic [4:0]  TOP16_G  = 5'd9;
  localparam logic [4:0]  TOP16_B  = 5'd4;
  localparam logic [4:0]  TOP32_R  = 5'd23;
  localparam logic [4:0]  TOP32_G  = 5'd15;
  localparam logic [4:0]  TOP32_B  = 5'd7;
  localparam logic [COL_W-1:0] WIDTH_RST = COL_W'(1);

  typedef struct packed {
    logic        operation;
    logic [63:0] source_word;
    logic [7:0]  palette_index;
    logic [7:0]  palette_red;
    logic [7:0]  palette_green;
    logic [7:0]  palette_blue;
  } in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       line_end;
    logic       last_of_run;
  } out_t;

  typedef struct packed {
    fmt_t             fmt;
    logic [COL_W-1:0] width;
    logic             custom;
    logic [31:0]      rmask;
    logic [31:0]      gmask;
    logic [31:0]      bmask;
    logic [4:0]       rtop;
    logic [4:0]       gtop;
    logic [4:0]       btop;
  } cfg_t;

  typedef enum logic [1:0] {JOB_PAL_WR, JOB_INDEX, JOB_MASKED, JOB_DIRECT} job_kind_t;
  typedef enum logic [1:0] {IDX_1BPP, IDX_4BPP, IDX_8BPP} idx_mode_t;

  typedef struct packed {
    job_kind_t   kind;
    idx_mode_t   idx_mode;
    logic        mset32;
    logic [2:0]  last_step;
    logic [7:0]  pal_idx;
    logic [23:0] rgb;
    logic [31:0] word;
  } job_t;

endpackage

>>> rtl/bitmap_pixel_to_rgb24_top.sv
// top level of the bitmap pixel to rgb24 converter
// depends on bp2r_pkg, bp2r_cfg, bp2r_front, bp2r_jobq, bp2r_back
//
// Each request is either a source word or a palette entry write. The back end
// emits one pixel per clock while the result queue has room; a 1 bpp word
// yields up to 8 pixels, a 4 bpp word up to 2 and every other format 1, and
// a palette write yields nothing. A short job queue lets new requests be
// taken while a byte is still being unpacked, and a 4-deep result queue
// decouples the consumer. The first pixel of a request is registered in the
// job queue, the back end stage and the result queue before it is output.
// The palette has no reset: entries must be written before they are looked up.
module bitmap_pixel_to_rgb24_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  input  bp2r_pkg::in_t                  in_data,
  output logic                           in_full,
  output logic                           out_empty,
  input  logic                           out_pop,
  output bp2r_pkg::out_t                 out_data,
  input  logic                           cfg_wr_en,
  input  logic [bp2r_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [bp2r_pkg::CFG_DW-1:0]    cfg_wr_data
);
  import bp2r_pkg::*;

  cfg_t cfg;
  job_t job, head;
  logic job_valid, jq_full, jq_empty, jq_pop;

  bp2r_cfg u_cfg (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_wr_data, .cfg
  );

  bp2r_front u_front (
    .in_push, .in_data, .in_full, .cfg, .jq_full, .job_valid, .job
  );

  bp2r_jobq u_jobq (
    .clk, .rst_n, .push(job_valid), .wdata(job), .pop(jq_pop), .rdata(head),
    .full(jq_full), .empty(jq_empty)
  );

  bp2r_back u_back (
    .clk, .rst_n, .cfg, .head, .head_empty(jq_empty), .jq_pop,
    .out_empty, .out_pop, .out_data
  );

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> !jq_full)
    else $error("job pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    jq_pop |-> !jq_empty)
    else $error("job popped from empty queue");

endmodule

>>> rtl/bp2r_cfg.sv
// configuration registers with precomputed top bit position of each mask
// depends on bp2r_pkg
module bp2r_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [bp2r_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [bp2r_pkg::CFG_DW-1:0]      cfg_wr_data,
  output bp2r_pkg::cfg_t                   cfg
);
  import bp2r_pkg::*;

  fmt_t             fmt_r;
  logic [COL_W-1:0] width_r;
  logic             custom_r;
  logic [31:0]      rmask_r, gmask_r, bmask_r;
  logic [4:0]       rtop_r, gtop_r, btop_r;
  logic [4:0]       wr_top;

  function automatic logic [4:0] top_bit(input logic [31:0] m);
    logic [4:0] t;
    t = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (m[i]) t = 5'(i);
    end
    return t;
  endfunction

  assign wr_top = top_bit(cfg_wr_data[31:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FMT_8BPP;
      width_r  <= WIDTH_RST;
      custom_r <= 1'b0;
      rmask_r  <= MASK16_R;
      gmask_r  <= MASK16_G;
      bmask_r  <= MASK16_B;
      rtop_r   <= TOP16_R;
      gtop_r   <= TOP16_G;
      btop_r   <= TOP16_B;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_FORMAT:     fmt_r    <= fmt_t'(cfg_wr_data[2:0]);
        REG_WIDTH:      width_r  <= cfg_wr_data[COL_W-1:0];
        REG_CUSTOM:     custom_r <= cfg_wr_data[0];
        REG_RED_MASK: begin
          rmask_r <= cfg_wr_data[31:0];
          rtop_r  <= wr_top;
        end
        REG_GREEN_MASK: begin
          gmask_r <= cfg_wr_data[31:0];
          gtop_r  <= wr_top;
        end
        REG_BLUE_MASK: begin
          bmask_r <= cfg_wr_data[31:0];
          btop_r  <= wr_top;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.fmt    = fmt_r;
    cfg.width  = width_r;
    cfg.custom = custom_r;
    cfg.rmask  = rmask_r;
    cfg.gmask  = gmask_r;
    cfg.bmask  = bmask_r;
    cfg.rtop   = rtop_r;
    cfg.gtop   = gtop_r;
    cfg.btop   = btop_r;
  end

endmodule

>>> rtl/bp2r_front.sv
// front end: accepts requests and classifies them into back end jobs
// depends on bp2r_pkg
module bp2r_front (
  input  logic           in_push,
  input  bp2r_pkg::in_t  in_data,
  output logic           in_full,
  input  bp2r_pkg::cfg_t cfg,
  input  logic           jq_full,
  output logic           job_valid,
  output bp2r_pkg::job_t job
);
  import bp2r_pkg::*;

  logic        accept;
  logic        keep;
  logic [63:0] w;

  assign in_full = jq_full;
  assign accept  = in_push && !jq_full;
  assign w       = in_data.source_word;

  always_comb begin
    keep          = 1'b1;
    job.kind      = JOB_DIRECT;
    job.idx_mode  = IDX_8BPP;
    job.mset32    = 1'b0;
    job.last_step = 3'd0;
    job.pal_idx   = in_data.palette_index;
    job.rgb       = {w[23:16], w[15:8], w[7:0]};
    job.word      = w[31:0];
    if (in_data.operation == OP_PAL_WR) begin
      job.kind = JOB_PAL_WR;
      job.rgb  = {in_data.palette_red, in_data.palette_green, in_data.palette_blue};
    end else begin
      case (cfg.fmt)
        FMT_1BPP: begin
          job.kind      = JOB_INDEX;
          job.idx_mode  = IDX_1BPP;
          job.last_step = 3'd7;
        end
        FMT_4BPP: begin
          job.kind      = JOB_INDEX;
          job.idx_mode  = IDX_4BPP;
          job.last_step = 3'd1;
        end
        FMT_8BPP: begin
          job.kind = JOB_INDEX;
        end
        FMT_16BPP: begin
          job.kind = JOB_MASKED;
          job.word = {16'd0, w[15:0]};
        end
        FMT_24BPP: begin
          job.kind = JOB_DIRECT;
        end
        FMT_32BPP: begin
          job.kind   = JOB_MASKED;
          job.mset32 = 1'b1;
        end
        FMT_64BPP: begin
          job.kind = JOB_DIRECT;
          job.rgb  = {w[39:32], w[23:16], w[7:0]};
        end
        default: keep = 1'b0;
      endcase
    end
  end

  assign job_valid = accept && keep;

endmodule

>>> rtl/bp2r_jobq.sv
// short job queue between the front end and the back end
// depends on bp2r_pkg
module bp2r_jobq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bp2r_pkg::job_t wdata,
  input  logic           pop,
  output bp2r_pkg::job_t rdata,
  output logic           full,
  output logic           empty
);
  import bp2r_pkg::*;

  localparam int PW = $clog2(JQ_DEPTH);
  localparam int CW = $clog2(JQ_DEPTH + 1);

  job_t          mem_r [JQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = cnt_r == CW'(JQ_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= PW'((CW'(wr_ptr_r) + 1'b1) % CW'(JQ_DEPTH));
      if (do_pop)  rd_ptr_r <= PW'((CW'(rd_ptr_r) + 1'b1) % CW'(JQ_DEPTH));
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

>>> rtl/bp2r_back.sv
// back end: per pixel sequencer, palette memory, channel alignment,
// column counter and result queue; depends on bp2r_pkg
module bp2r_back (
  input  logic           clk,
  input  logic           rst_n,
  input  bp2r_pkg::cfg_t cfg,
  input  bp2r_pkg::job_t head,
  input  logic           head_empty,
  output logic           jq_pop,
  output logic           out_empty,
  input  logic           out_pop,
  output bp2r_pkg::out_t out_data
);
  import bp2r_pkg::*;

  localparam int OPW = $clog2(OQ_DEPTH);
  localparam int OCW = $clog2(OQ_DEPTH + 1);
  localparam logic [PAL_AW:0] PAL_LIMIT = (PAL_AW + 1)'(PAL_ENTRIES);

  function automatic logic [7:0] align(input logic [31:0] px, input logic [31:0] m,
                                       input logic [4:0] top);
    logic [38:0] f;
    f = {px & m, 7'd0} >> top;
    return f[7:0];
  endfunction

  logic [23:0]      pal_mem [PAL_ENTRIES];
  logic [23:0]      pal_q_r;
  logic [2:0]       step_r;
  logic [COL_W-1:0] col_r;

  logic             b_valid_r, b_idx_r, b_inr_r, b_end_r, b_last_r;
  logic [23:0]      b_rgb_r;

  out_t             oq_r [OQ_DEPTH];
  logic [OPW-1:0]   owr_r, ord_r;
  logic [OCW-1:0]   ocnt_r;

  logic             room, is_pix, issue, palwr, last;
  logic [7:0]       byte0, idx;
  logic             idx_inr, wr_inr;
  logic [31:0]      rm, gm, bm;
  logic [4:0]       rt, gt, bt;
  logic [23:0]      rgb_nxt;
  logic [COL_W-1:0] w_eff;
  logic [COL_W:0]   col_inc;
  logic             line_end;
  logic [23:0]      b_color;
  logic             o_pop;

  assign room   = ((OCW + 1)'(ocnt_r) + (OCW + 1)'(b_valid_r)) < (OCW + 1)'(OQ_DEPTH);
  assign is_pix = head.kind != JOB_PAL_WR;
  assign issue  = !head_empty && is_pix && room;
  assign palwr  = !head_empty && !is_pix;
  assign byte0  = head.word[7:0];

  always_comb begin
    case (head.idx_mode)
      IDX_1BPP: idx = {7'd0, byte0[~step_r]};
      IDX_4BPP: idx = step_r[0] ? {4'd0, byte0[3:0]} : {4'd0, byte0[7:4]};
      default:  idx = byte0;
    endcase
  end

  assign idx_inr = {1'b0, idx} < PAL_LIMIT;
  assign wr_inr  = {1'b0, head.pal_idx} < PAL_LIMIT;

  always_comb begin
    if (cfg.custom) begin
      rm = cfg.rmask;  gm = cfg.gmask;  bm = cfg.bmask;
      rt = cfg.rtop;   gt = cfg.gtop;   bt = cfg.btop;
    end else if (head.mset32) begin
      rm = MASK32_R;   gm = MASK32_G;   bm = MASK32_B;
      rt = TOP32_R;    gt = TOP32_G;    bt = TOP32_B;
    end else begin
      rm = MASK16_R;   gm = MASK16_G;   bm = MASK16_B;
      rt = TOP16_R;    gt = TOP16_G;    bt = TOP16_B;
    end
  end

  assign rgb_nxt = (head.kind == JOB_MASKED) ?
                   {align(head.word, rm, rt), align(head.word, gm, gt),
                    align(head.word, bm, bt)} : head.rgb;

  // column counter: a zero width acts as one
  assign w_eff    = (cfg.width == '0) ? COL_W'(1) : cfg.width;
  assign col_inc  = {1'b0, col_r} + (COL_W + 1)'(1);
  assign line_end = (col_inc >= {1'b0, w_eff}) || (col_inc[COL_W-1:0] == '0);
  assign last     = line_end || (step_r == head.last_step);
  assign jq_pop   = palwr || (issue && last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= '0;
      col_r     <= '0;
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= issue;
      if (issue) begin
        step_r <= last ? 3'd0 : step_r + 3'd1;
        col_r  <= line_end ? '0 : col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_idx_r  <= head.kind == JOB_INDEX;
      b_inr_r  <= idx_inr;
      b_end_r  <= line_end;
      b_last_r <= last;
      b_rgb_r  <= rgb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (palwr && wr_inr) pal_mem[head.pal_idx[PAL_AW-1:0]] <= head.rgb;
    if (issue) pal_q_r <= pal_mem[idx[PAL_AW-1:0]];
  end

  assign b_color = b_idx_r ? (b_inr_r ? pal_q_r : 24'd0) : b_rgb_r;

  // result queue
  assign out_empty = ocnt_r == '0;
  assign out_data  = oq_r[ord_r];
  assign o_pop     = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= '0;
      ord_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (b_valid_r) owr_r <= OPW'((OCW'(owr_r) + 1'b1) % OCW'(OQ_DEPTH));
      if (o_pop)     ord_r <= OPW'((OCW'(ord_r) + 1'b1) % OCW'(OQ_DEPTH));
      ocnt_r <= ocnt_r + OCW'(b_valid_r) - OCW'(o_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid_r) begin
      oq_r[owr_r] <= '{red: b_color[23:16], green: b_color[15:8], blue: b_color[7:0],
                       line_end: b_end_r, last_of_run: b_last_r};
    end
  end

endmodule
